>>> rtl/ioqt_pkg.sv
// Package for the interval overlap query table: payload structs, codes and sizes.
// No dependencies; used by every module of the block.
`default_nettype none
package ioqt_pkg;
    localparam int TableDepth = 32;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_OVERLAP = 2'd2;
    localparam logic [1:0] CMD_NEAREST = 2'd3;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_OVERLAP = 3'd2;
    localparam logic [2:0] ST_NEAREST = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] range_start;
        logic [31:0] range_stop;
        logic [7:0]  speaker_id;
        logic [31:0] probe_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  hit_speaker;
        logic [31:0] overlap_length;
        logic        last_result;
    } t_out_item;
endpackage
`default_nettype wire

>>> rtl/interval_overlap_query_table_core.sv
// Top level of the interval overlap query table: front queue plus back engine.
// Depends on ioqt_pkg, ioqt_front and ioqt_back.
//
// Usage: items arrive on the i_in channel (valid/ready) and results leave on
// the o_out channel. A load or clear gives one result with status accepted or
// table full. An overlap query walks the table one entry per cycle and emits
// every hit in table order, the final one marked by last_result; a miss gives
// one none-found result. A nearest query walks all entries, one per cycle, and
// gives one result. A load finds its slot by shifting entries up one per cycle.
// An overlap query pauses its walk at each hit after the first to emit the one before.
// A two-entry queue lets new items be taken while the engine is busy.
// A held result stalls the walk until the receiver takes it.
// Reset empties the table and the queue; stored turns need no clearing.
`default_nettype none
module interval_overlap_query_table_core import ioqt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);
    logic     w_q_valid, w_q_ready;
    t_in_item w_q_data;

    ioqt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_q_valid(w_q_valid), .i_q_ready(w_q_ready), .o_q_data(w_q_data)
    );

    ioqt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .o_q_ready(w_q_ready), .i_q_data(w_q_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

`ifndef SYNTH
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_NONE)
        else $error("bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result not held");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OVERLAP |-> o_out_data.overlap_length == 0)
        else $error("length on non-overlap result");
`endif
endmodule
`default_nettype wire

>>> rtl/ioqt_front.sv
// Front end: accepts input items and holds them in a two-entry queue.
// Depends on ioqt_pkg.
`default_nettype none
module ioqt_front import ioqt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_q_valid,
    input  wire logic     i_q_ready,
    output t_in_item      o_q_data
);
    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_mem[r_rp];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_in_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/ioqt_back.sv
// Back end: table storage, insertion shift, overlap scan and nearest search.
// Depends on ioqt_pkg.
`default_nettype none
module ioqt_back import ioqt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    output logic          o_q_ready,
    input  wire t_in_item i_q_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_NEAR = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    logic [31:0] r_start [TableDepth];
    logic [31:0] r_stop  [TableDepth];
    logic [7:0]  r_spk   [TableDepth];
    logic [CntW-1:0] r_count, r_i;
    logic [2:0]  r_state;
    t_in_item    r_cmd;
    logic        r_have;
    logic [34:0] r_best;
    logic [7:0]  r_best_spk;
    logic        r_ov;
    t_out_item   r_out;
    logic        r_out_valid;

    logic [IdxW-1:0] w_idx, w_prev;
    logic [31:0] w_hi, w_lo;
    logic [34:0] w_sum, w_dist;
    logic        w_slot;
    logic        w_hit;

    assign w_idx  = r_i[IdxW-1:0];
    assign w_prev = w_idx - 1'b1;
    assign w_hi   = (r_stop[w_idx] < r_cmd.range_stop) ? r_stop[w_idx] : r_cmd.range_stop;
    assign w_lo   = (r_start[w_idx] > r_cmd.range_start) ? r_start[w_idx] : r_cmd.range_start;
    assign w_hit  = w_hi > w_lo;
    assign w_sum  = {3'b0, r_start[w_idx]} + {3'b0, r_stop[w_idx]}
                  - {2'b0, r_cmd.probe_time, 1'b0};
    assign w_dist = w_sum[34] ? (~w_sum + 35'd1) : w_sum;
    assign w_slot = !r_out_valid || i_out_ready;
    assign o_q_ready   = (r_state == S_IDLE) && w_slot;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT) begin
            if (r_i != 0 && r_start[w_prev] > r_cmd.range_start) begin
                r_start[w_idx] <= r_start[w_prev];
                r_stop[w_idx]  <= r_stop[w_prev];
                r_spk[w_idx]   <= r_spk[w_prev];
            end else begin
                r_start[w_idx] <= r_cmd.range_start;
                r_stop[w_idx]  <= r_cmd.range_stop;
                r_spk[w_idx]   <= r_cmd.speaker_id;
            end
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_have      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && w_slot) begin
                        r_cmd <= i_q_data;
                        r_i   <= '0;
                        r_have <= 1'b0;
                        r_ov   <= 1'b0;
                        case (i_q_data.command)
                            CMD_LOAD: begin
                                if (r_count == CntW'(TableDepth)) begin
                                    r_out <= '{ST_FULL, 8'd0, 32'd0, 1'b1};
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_i <= r_count;
                                    r_state <= S_SHIFT;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_out <= '{ST_ACCEPTED, 8'd0, 32'd0, 1'b1};
                                r_out_valid <= 1'b1;
                            end
                            CMD_OVERLAP: r_state <= S_SCAN;
                            default: r_state <= S_NEAR;
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (r_i != 0 && r_start[w_prev] > r_cmd.range_start) begin
                        r_i <= r_i - 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_out <= '{ST_ACCEPTED, 8'd0, 32'd0, 1'b1};
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_i == r_count) begin
                        if (w_slot) begin
                            if (r_ov) begin
                                r_out.last_result <= 1'b1;
                            end else begin
                                r_out <= '{ST_NONE, 8'd0, 32'd0, 1'b1};
                            end
                            r_out_valid <= 1'b1;
                            r_state <= S_HOLD;
                        end
                    end else if (!w_hit) begin
                        r_i <= r_i + 1'b1;
                    end else if (!r_ov) begin
                        if (w_slot) begin
                            r_out <= '{ST_OVERLAP, r_spk[w_idx], w_hi - w_lo, 1'b0};
                            r_ov  <= 1'b1;
                            r_i   <= r_i + 1'b1;
                        end
                    end else if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_ov  <= 1'b0;
                    end
                end
                S_HOLD: begin
                    if (w_slot || !r_out_valid) r_state <= S_IDLE;
                end
                S_NEAR: begin
                    if (r_i == r_count) begin
                        if (w_slot) begin
                            r_out <= r_have ? '{ST_NEAREST, r_best_spk, 32'd0, 1'b1}
                                            : '{ST_NONE, 8'd0, 32'd0, 1'b1};
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (!r_have || w_dist < r_best) begin
                            r_best <= w_dist;
                            r_best_spk <= r_spk[w_idx];
                        end
                        r_have <= 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
